// File: hdl/che_pkg.sv
`timescale 1ns / 1ps

package che_pkg;

  // field widths
  localparam int T_W = 17;
  localparam int D_W = 32;

  // stream bus widths and field offsets
  localparam int S_TDATA_W = 152;
  localparam int M_TDATA_W = 96;
  localparam int T_LSB     = 0;
  localparam int A_LSB     = T_LSB + T_W;
  localparam int B_LSB     = A_LSB + D_W;
  localparam int TA_LSB    = B_LSB + D_W;
  localparam int TB_LSB    = TA_LSB + D_W;
  localparam int POS_LSB   = 0;
  localparam int VEL_LSB   = POS_LSB + D_W;
  localparam int ACC_LSB   = VEL_LSB + D_W;

  // pipeline depth
  localparam int N_STG = 8;

  // datapath widths
  localparam int K_W     = 36;
  localparam int M1_W    = K_W + T_W + 1;
  localparam int P1_W    = M1_W + 1;
  localparam int V1_W    = M1_W + 2;
  localparam int P_SPLIT = 27;
  localparam int V_SPLIT = 28;
  localparam int PH_W    = P1_W - P_SPLIT;
  localparam int VH_W    = V1_W - V_SPLIT;
  localparam int PLP_W   = P_SPLIT + T_W;
  localparam int PHP_W   = PH_W + T_W + 1;
  localparam int VLP_W   = V_SPLIT + T_W;
  localparam int VHP_W   = VH_W + T_W + 1;
  localparam int P2_W    = P1_W + T_W + 1;
  localparam int V2_W    = V1_W + T_W + 1;
  localparam int Q_SPLIT = 36;
  localparam int QH_W    = P2_W - Q_SPLIT;
  localparam int QLP_W   = Q_SPLIT + T_W;
  localparam int QHP_W   = QH_W + T_W + 1;
  localparam int P3_W    = P2_W + T_W + 1;
  localparam int SAT_W   = 48;

  // scaling
  localparam int K2_P_SHIFT = 16;
  localparam int K2_V_SHIFT = 17;
  localparam int TA_SHIFT   = 32;
  localparam int A_SHIFT    = 48;
  localparam int FRAC_P     = 48;
  localparam int FRAC_V     = 32;
  localparam int FRAC_A     = 16;

  function automatic logic [D_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-D_W:0] top;
    top = x[SAT_W-1:D_W-1];
    if (top == '0 || top == '1) begin
      return x[D_W-1:0];
    end else if (x[SAT_W-1]) begin
      return {1'b1, {(D_W-1){1'b0}}};
    end else begin
      return {1'b0, {(D_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: hdl/cubic_hermite_evaluator_top.sv
`timescale 1ns / 1ps
// cubic hermite segment evaluator, one coordinate axis per transaction
// slave side: s_axis_tvalid / s_axis_tready / s_axis_tdata carry t (unsigned q1.16),
//   the two end points and the two end tangents (q16.16)
// master side: m_axis_tvalid / m_axis_tready / m_axis_tdata carry position,
//   velocity and acceleration (q16.16, rounded to nearest, saturated)
// pipeline: the datapath is an 8-stage pipeline with a valid bit per stage;
//   an accepted input passes the stage registers s1 to s8 in order, and
//   m_axis_tvalid is the valid bit of s8, the output register
// throughput: one transaction per cycle while the output is not stalled; the
//   polynomial is evaluated in horner form and each wide product with t is cut
//   into two partial products in their own stage, which sets the stage count
// stall: when m_axis_tready is low the result holds in the output register and
//   earlier stages keep filling empty slots; s_axis_tready drops only once
//   every stage holds an item
// reset: rst_ni clears the stage valid bits only; the block is ready
//   right after reset

module cubic_hermite_evaluator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // param_t, point_a, point_b, tangent_a, tangent_b, 7 unused bits
  input  logic [che_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // position, velocity, acceleration
  output logic [che_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  import che_pkg::*;

  logic [N_STG-1:0] vld_q;
  logic [N_STG-1:0] en;

  // input unpack
  logic        [T_W-1:0] in_t;
  logic signed [D_W-1:0] in_a, in_b, in_ta, in_tb;
  logic signed [K_W-1:0] ax, bx, tax, tbx, dx;

  // stage 1
  logic        [T_W-1:0] s1_t_q;
  logic signed [D_W-1:0] s1_a_q, s1_ta_q;
  logic signed [K_W-1:0] s1_k2_q, s1_k3_q, s1_k2_d, s1_k3_d;
  // stage 2
  logic        [T_W-1:0]  s2_t_q;
  logic signed [D_W-1:0]  s2_a_q, s2_ta_q;
  logic signed [K_W-1:0]  s2_k2_q;
  logic signed [M1_W-1:0] s2_m1_q, s2_m1_d;
  logic signed [T_W:0]    s1_tx;
  // stage 3
  logic        [T_W-1:0]  s3_t_q;
  logic signed [D_W-1:0]  s3_a_q, s3_ta_q;
  logic signed [P1_W-1:0] s3_p1_q, s3_p1_d;
  logic signed [V1_W-1:0] s3_v1_q, s3_v1_d, s3_ac_q, s3_ac_d, m1x;
  // stage 4
  logic        [T_W-1:0]   s4_t_q;
  logic signed [D_W-1:0]   s4_a_q, s4_ta_q;
  logic        [PLP_W-1:0] s4_pl_q, s4_pl_d;
  logic signed [PHP_W-1:0] s4_ph_q, s4_ph_d;
  logic        [VLP_W-1:0] s4_vl_q, s4_vl_d;
  logic signed [VHP_W-1:0] s4_vh_q, s4_vh_d;
  logic        [D_W-1:0]   s4_acc_q, s4_acc_d;
  logic signed [T_W:0]     s3_tx;
  logic signed [PH_W-1:0]  s3_ph;
  logic signed [VH_W-1:0]  s3_vh;
  logic signed [V1_W-1:0]  s3_ac_rnd;
  // stage 5
  logic        [T_W-1:0]  s5_t_q;
  logic signed [D_W-1:0]  s5_a_q;
  logic signed [P2_W-1:0] s5_p2_q, s5_p2_d;
  logic signed [V2_W-1:0] s5_v2_q, s5_v2_d;
  logic        [D_W-1:0]  s5_acc_q;
  // stage 6
  logic signed [D_W-1:0]   s6_a_q;
  logic        [QLP_W-1:0] s6_ql_q, s6_ql_d;
  logic signed [QHP_W-1:0] s6_qh_q, s6_qh_d;
  logic        [D_W-1:0]   s6_vel_q, s6_vel_d, s6_acc_q;
  logic signed [T_W:0]     s5_tx;
  logic signed [QH_W-1:0]  s5_qh;
  logic signed [V2_W-1:0]  s5_v_rnd;
  // stage 7
  logic signed [P3_W-1:0] s7_p3_q, s7_p3_d;
  logic        [D_W-1:0]  s7_vel_q, s7_acc_q;
  // stage 8, output register
  logic        [D_W-1:0]  s8_pos_q, s8_pos_d, s8_vel_q, s8_acc_q;
  logic signed [P3_W-1:0] s7_p_rnd;

  // stage enables, an empty stage always takes the next item
  always_comb begin
    en[N_STG-1] = !vld_q[N_STG-1] || m_axis_tready;
    for (int i = N_STG - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[N_STG-1];
  assign m_axis_tdata  = {s8_acc_q, s8_vel_q, s8_pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < N_STG; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // stage 1: cubic and quadratic coefficients
  assign in_t  = s_axis_tdata[T_LSB +: T_W];
  assign in_a  = signed'(s_axis_tdata[A_LSB +: D_W]);
  assign in_b  = signed'(s_axis_tdata[B_LSB +: D_W]);
  assign in_ta = signed'(s_axis_tdata[TA_LSB +: D_W]);
  assign in_tb = signed'(s_axis_tdata[TB_LSB +: D_W]);
  assign ax    = K_W'(in_a);
  assign bx    = K_W'(in_b);
  assign tax   = K_W'(in_ta);
  assign tbx   = K_W'(in_tb);
  assign dx    = bx - ax;

  assign s1_k2_d = dx + (dx <<< 1) - (tax <<< 1) - tbx;
  assign s1_k3_d = tax + tbx - (dx <<< 1);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_t_q  <= in_t;
      s1_a_q  <= in_a;
      s1_ta_q <= in_ta;
      s1_k2_q <= s1_k2_d;
      s1_k3_q <= s1_k3_d;
    end
  end

  // stage 2: k3 * t
  assign s1_tx   = signed'({1'b0, s1_t_q});
  assign s2_m1_d = s1_k3_q * s1_tx;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_t_q  <= s1_t_q;
      s2_a_q  <= s1_a_q;
      s2_ta_q <= s1_ta_q;
      s2_k2_q <= s1_k2_q;
      s2_m1_q <= s2_m1_d;
    end
  end

  // stage 3: inner horner terms for the three outputs
  assign m1x     = V1_W'(s2_m1_q);
  assign s3_p1_d = P1_W'(s2_m1_q) + (P1_W'(s2_k2_q) <<< K2_P_SHIFT);
  assign s3_v1_d = m1x + (m1x <<< 1) + (V1_W'(s2_k2_q) <<< K2_V_SHIFT);
  assign s3_ac_d = (m1x <<< 2) + (m1x <<< 1) + (V1_W'(s2_k2_q) <<< K2_V_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_t_q  <= s2_t_q;
      s3_a_q  <= s2_a_q;
      s3_ta_q <= s2_ta_q;
      s3_p1_q <= s3_p1_d;
      s3_v1_q <= s3_v1_d;
      s3_ac_q <= s3_ac_d;
    end
  end

  // stage 4: split products with t, acceleration done
  assign s3_tx     = signed'({1'b0, s3_t_q});
  assign s3_ph     = signed'(s3_p1_q[P1_W-1:P_SPLIT]);
  assign s3_vh     = signed'(s3_v1_q[V1_W-1:V_SPLIT]);
  assign s4_pl_d   = s3_p1_q[P_SPLIT-1:0] * s3_t_q;
  assign s4_ph_d   = s3_ph * s3_tx;
  assign s4_vl_d   = s3_v1_q[V_SPLIT-1:0] * s3_t_q;
  assign s4_vh_d   = s3_vh * s3_tx;
  assign s3_ac_rnd = s3_ac_q + (V1_W'(1) <<< (FRAC_A - 1));
  assign s4_acc_d  = sat32(SAT_W'(signed'(s3_ac_rnd[V1_W-1:FRAC_A])));

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_t_q   <= s3_t_q;
      s4_a_q   <= s3_a_q;
      s4_ta_q  <= s3_ta_q;
      s4_pl_q  <= s4_pl_d;
      s4_ph_q  <= s4_ph_d;
      s4_vl_q  <= s4_vl_d;
      s4_vh_q  <= s4_vh_d;
      s4_acc_q <= s4_acc_d;
    end
  end

  // stage 5: recombine partial products, add tangent term
  assign s5_p2_d = (P2_W'(s4_ph_q) <<< P_SPLIT) + P2_W'(s4_pl_q)
                 + (P2_W'(s4_ta_q) <<< TA_SHIFT);
  assign s5_v2_d = (V2_W'(s4_vh_q) <<< V_SPLIT) + V2_W'(s4_vl_q)
                 + (V2_W'(s4_ta_q) <<< TA_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_t_q   <= s4_t_q;
      s5_a_q   <= s4_a_q;
      s5_p2_q  <= s5_p2_d;
      s5_v2_q  <= s5_v2_d;
      s5_acc_q <= s4_acc_q;
    end
  end

  // stage 6: last split product for position, velocity done
  assign s5_tx    = signed'({1'b0, s5_t_q});
  assign s5_qh    = signed'(s5_p2_q[P2_W-1:Q_SPLIT]);
  assign s6_ql_d  = s5_p2_q[Q_SPLIT-1:0] * s5_t_q;
  assign s6_qh_d  = s5_qh * s5_tx;
  assign s5_v_rnd = s5_v2_q + (V2_W'(1) <<< (FRAC_V - 1));
  assign s6_vel_d = sat32(SAT_W'(signed'(s5_v_rnd[V2_W-1:FRAC_V])));

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_a_q   <= s5_a_q;
      s6_ql_q  <= s6_ql_d;
      s6_qh_q  <= s6_qh_d;
      s6_vel_q <= s6_vel_d;
      s6_acc_q <= s5_acc_q;
    end
  end

  // stage 7: full position sum
  assign s7_p3_d = (P3_W'(s6_qh_q) <<< Q_SPLIT) + P3_W'(s6_ql_q)
                 + (P3_W'(s6_a_q) <<< A_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_p3_q  <= s7_p3_d;
      s7_vel_q <= s6_vel_q;
      s7_acc_q <= s6_acc_q;
    end
  end

  // stage 8: round and saturate position into the output register
  assign s7_p_rnd = s7_p3_q + (P3_W'(1) <<< (FRAC_P - 1));
  assign s8_pos_d = sat32(SAT_W'(signed'(s7_p_rnd[P3_W-1:FRAC_P])));

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_pos_q <= s8_pos_d;
      s8_vel_q <= s7_vel_q;
      s8_acc_q <= s7_acc_q;
    end
  end

`ifndef SYNTH
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("not ready while output register empty");

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld_q) && !m_axis_tready |-> !s_axis_tready)
    else $error("ready while pipeline full and stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted transaction missing in first stage");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !vld_q[N_STG-2] |=> !m_axis_tvalid)
    else $error("output valid without an item behind it");
`endif

endmodule

// File: test/cubic_hermite_evaluator_top_tb.sv
`timescale 1ns / 1ps

module cubic_hermite_evaluator_top_tb;
  import che_pkg::*;

  typedef struct packed {
    logic [T_W-1:0]        t;
    logic signed [D_W-1:0] a;
    logic signed [D_W-1:0] b;
    logic signed [D_W-1:0] ta;
    logic signed [D_W-1:0] tb;
  } hseg_t;

  typedef struct packed {
    logic signed [D_W-1:0] pos;
    logic signed [D_W-1:0] vel;
    logic signed [D_W-1:0] acc;
  } kin_t;

  typedef struct packed {
    hseg_t seg;
    logic  typed;
    kin_t  want;
  } hrow_t;

  localparam logic [T_W-1:0] T_ZERO = 17'd0;
  localparam logic [T_W-1:0] T_HALF = 17'd32768;
  localparam logic [T_W-1:0] T_ONE  = 17'd65536;
  localparam logic [T_W-1:0] T_TOP  = 17'h1ffff;

  localparam logic signed [D_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [D_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [D_W-1:0] S32_MIN = 32'sh8000_0000;

  localparam int N_ROWS     = 18;
  localparam int RAND_ITEMS = 1890;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_LEN   = 100;

  // typed expectations only where they read straight off the polynomials
  localparam hrow_t DIR_ROWS [N_ROWS] = '{
    '{'{T_ZERO, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}},
    '{'{T_ZERO, Q_ONE, 0, 0, 0}, 1'b1, '{Q_ONE, 0, -32'sd393216}},
    '{'{T_ONE, 0, Q_ONE, 0, 0}, 1'b1, '{Q_ONE, 0, -32'sd393216}},
    '{'{T_ZERO, 0, 0, Q_ONE, 0}, 1'b1, '{0, Q_ONE, -32'sd262144}},
    '{'{T_ONE, 0, 0, 0, Q_ONE}, 1'b1, '{0, Q_ONE, 32'sd262144}},
    '{'{T_ZERO, S32_MAX, S32_MIN, S32_MIN, S32_MAX}, 1'b1, '{S32_MAX, S32_MIN, S32_MIN}},
    '{'{T_ZERO, S32_MIN, S32_MAX, S32_MAX, S32_MIN}, 1'b1, '{S32_MIN, S32_MAX, S32_MAX}},
    '{'{T_ONE, 0, S32_MAX, 0, S32_MIN}, 1'b1, '{S32_MAX, S32_MIN, S32_MIN}},
    // half-lsb ties round up
    '{'{T_HALF, 32'sd1, 0, 0, 0}, 1'b1, '{32'sd1, -32'sd1, 0}},
    '{'{T_HALF, -32'sd1, 0, 0, 0}, 1'b1, '{0, 32'sd2, 0}},
    // untyped rows, the first four extrapolating past one
    '{'{T_TOP, S32_MAX, S32_MAX, S32_MAX, S32_MAX}, 1'b0, '0},
    '{'{T_TOP, S32_MIN, S32_MIN, S32_MIN, S32_MIN}, 1'b0, '0},
    '{'{T_TOP, S32_MAX, S32_MIN, S32_MAX, S32_MIN}, 1'b0, '0},
    '{'{17'd65537, 32'sd100, -32'sd100, 32'sd7, -32'sd7}, 1'b0, '0},
    '{'{17'd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b0, '0},
    '{'{17'd65535, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh3333_3333, 32'shcccc_cccc},
      1'b0, '0},
    '{'{17'h0aaaa, 32'sh1234_5678, -32'sh0fed_cba9, 32'sh0000_8000, -32'sh7000_0000},
      1'b0, '0},
    '{'{T_HALF, Q_ONE, -Q_ONE, 32'sh0003_0000, -32'sh0002_0000}, 1'b0, '0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  kin_t kin_expected [$];
  kin_t kin_got;
  kin_t kin_want;
  int   n_err;
  int   n_sent;
  int   burst_left;

  cubic_hermite_evaluator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic signed [127:0] widen(input longint v);
    return v;
  endfunction

  // exact weighted sum in units of 2^-48, rounded once, then saturated
  function automatic logic signed [D_W-1:0] blend(input longint w0, input longint w1,
                                                   input longint w2, input longint w3,
                                                   input hseg_t s);
    logic signed [127:0] sum;
    sum = widen(w0) * widen(s.a) + widen(w1) * widen(s.b)
        + widen(w2) * widen(s.ta) + widen(w3) * widen(s.tb);
    sum = sum + (128'sd1 <<< 47);
    sum = sum >>> 48;
    if (sum > widen(S32_MAX)) return S32_MAX;
    if (sum < widen(S32_MIN)) return S32_MIN;
    return sum[D_W-1:0];
  endfunction

  function automatic kin_t hermite_eval(input hseg_t s);
    longint tq;
    longint c3;
    longint c2;
    longint c1;
    longint c0;
    kin_t   k;
    tq = longint'(s.t);
    c3 = tq * tq * tq;
    c2 = tq * tq * 64'd65536;
    c1 = tq * 64'd65536 * 64'd65536;
    c0 = 64'd1 << 48;
    k.pos = blend(2 * c3 - 3 * c2 + c0, -2 * c3 + 3 * c2, c3 - 2 * c2 + c1, c3 - c2, s);
    k.vel = blend(6 * c2 - 6 * c1, -6 * c2 + 6 * c1, 3 * c2 - 4 * c1 + c0,
                  3 * c2 - 2 * c1, s);
    k.acc = blend(12 * c1 - 6 * c0, -12 * c1 + 6 * c0, 6 * c1 - 4 * c0, 6 * c1 - 2 * c0, s);
    return k;
  endfunction

  function automatic logic [T_W-1:0] rand_param();
    case ($urandom_range(0, 9))
      0: return T_ZERO;
      1: return T_ONE;
      2: return T_W'($urandom_range(65537, 131071));
      default: return T_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic signed [D_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return S32_MAX;
      1: return S32_MIN;
      2, 3: return $urandom;
      default: return D_W'($urandom_range(0, 1 << 23)) - (1 << 22);
    endcase
  endfunction

  // one segment transaction, with the sender's burst and gap pattern ahead of it
  task automatic drive_seg(input hseg_t s, input logic typed, input kin_t want);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = '0;
    s_axis_tdata[T_LSB +: T_W] = s.t;
    s_axis_tdata[A_LSB +: D_W] = s.a;
    s_axis_tdata[B_LSB +: D_W] = s.b;
    s_axis_tdata[TA_LSB +: D_W] = s.ta;
    s_axis_tdata[TB_LSB +: D_W] = s.tb;
    do @(posedge clk_i); while (!s_axis_tready);
    kin_expected.push_back(typed ? want : hermite_eval(s));
    n_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    hseg_t seg;
    logic  paused;
    n_err = 0;
    n_sent = 0;
    burst_left = 0;
    paused = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (DIR_ROWS[i]) drive_seg(DIR_ROWS[i].seg, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    // one t per point, three axes each
    for (int i = 0; i < RAND_ITEMS; i += 3) begin
      if (!paused && i >= RAND_ITEMS / 2) begin
        s_axis_tvalid = 1'b0;
        while (kin_expected.size() != 0) @(negedge clk_i);
        paused = 1'b1;
      end
      seg.t = rand_param();
      for (int ax = 0; ax < 3; ax++) begin
        seg.a = rand_coord();
        seg.b = rand_coord();
        seg.ta = rand_coord();
        seg.tb = rand_coord();
        drive_seg(seg, 1'b0, '0);
      end
    end
    s_axis_tvalid = 1'b0;
    while (kin_expected.size() != 0) @(negedge clk_i);
    repeat (3 * N_STG) @(negedge clk_i);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: phases of free flow, random stalls and heavy stalls, plus one long hold
  initial begin
    int   phase_left;
    int   mode;
    logic held;
    phase_left = 0;
    mode = 0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held && n_sent >= HOLD_AFTER) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk_i);
        held = 1'b1;
      end else begin
        if (phase_left == 0) begin
          mode = $urandom_range(0, 2);
          phase_left = $urandom_range(10, 80);
        end
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          default: m_axis_tready = ($urandom_range(0, 4) == 0);
        endcase
        phase_left--;
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      kin_got.pos = m_axis_tdata[POS_LSB +: D_W];
      kin_got.vel = m_axis_tdata[VEL_LSB +: D_W];
      kin_got.acc = m_axis_tdata[ACC_LSB +: D_W];
      if (kin_expected.size() == 0) begin
        $error("result transaction with nothing outstanding");
        n_err++;
      end else begin
        kin_want = kin_expected.pop_front();
        if (kin_got.pos !== kin_want.pos) begin
          $error("position mismatch: expected %0d, got %0d", kin_want.pos, kin_got.pos);
          n_err++;
        end
        if (kin_got.vel !== kin_want.vel) begin
          $error("velocity mismatch: expected %0d, got %0d", kin_want.vel, kin_got.vel);
          n_err++;
        end
        if (kin_got.acc !== kin_want.acc) begin
          $error("acceleration mismatch: expected %0d, got %0d", kin_want.acc, kin_got.acc);
          n_err++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
